### rtl/assert_macros.svh
// Shared concurrent assertion macros; expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication.
`define ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### rtl/sqve_pkg.sv
`default_nettype none

package sqve_pkg;

  localparam logic [1:0] CORNER_FIRST = 2'd0;
  localparam logic [1:0] CORNER_LAST  = 2'd3;

  typedef struct packed {
    logic               batch_start;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] size_x;
    logic signed [31:0] size_y;
    logic signed [31:0] uv_left;
    logic signed [31:0] uv_top;
    logic signed [31:0] uv_width;
    logic signed [31:0] uv_height;
    logic        [63:0] color_rgba;
    logic        [31:0] rotation;
    logic        [31:0] texture_id;
  } sqve_in_t;

  typedef struct packed {
    logic signed [31:0] vert_pos_x;
    logic signed [31:0] vert_pos_y;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic        [31:0] packed_color;
    logic        [31:0] vert_rotation;
    logic        [3:0]  tex_slot;
    logic               slot_overflow;
    logic        [1:0]  corner;
    logic               last_corner;
  } sqve_out_t;

  typedef struct packed {
    logic       load_in;
    logic       load_sprite;
    logic       load_vert;
    logic [1:0] corner;
  } sqve_cmd_t;

  // floor(c * 255 / 32768), clamp to 255
  function automatic logic [7:0] chan8(input logic [15:0] c);
    logic [23:0] prod;
    logic [8:0]  v;
    prod = {c, 8'd0} - {8'd0, c};
    v    = prod[23:15];
    return v[8] ? 8'hFF : v[7:0];
  endfunction

endpackage

`default_nettype wire

### rtl/sprite_quad_vertex_expander_top.sv
// Channel  Ports                         Word
// input    in_valid  in_ready  in_data   one sprite (sqve_in_t)
// output   out_valid out_ready out_data  one corner vertex (sqve_out_t)
//
// The output register takes one vertex per cycle unless the output stalls, four vertices per sprite.
// An accepted sprite passes the input register, then the sprite register, then the output reg.
// The next sprite is taken into the input register while the current quad is emitted.
// Reset empties the texture slot table; slot ids need no clearing.
// A stalled output holds the vertex and freezes the corner count.
`default_nettype none

module sprite_quad_vertex_expander_top #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sqve_pkg::sqve_in_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sqve_pkg::sqve_out_t      out_data
);
  import sqve_pkg::*;

  sqve_cmd_t cmd;

  sqve_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  sqve_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .out_data (out_data)
  );

endmodule

`default_nettype wire

### rtl/sqve_ctrl.sv
`default_nettype none

module sqve_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sqve_pkg::sqve_cmd_t      cmd
);
  import sqve_pkg::*;

  `include "assert_macros.svh"

  typedef enum logic {S_EMPTY, S_EMIT} sprite_state_t;

  sprite_state_t state_r, state_nxt;
  logic [1:0]    corner_r, corner_nxt;
  logic          in_full_r, in_full_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          out_free, load_vert, last, sprite_free, load_sprite, load_in;

  always_comb begin
    out_free    = !out_valid_r || out_ready;
    load_vert   = (state_r == S_EMIT) && out_free;
    last        = corner_r == CORNER_LAST;
    sprite_free = (state_r == S_EMPTY) || (load_vert && last);
    load_sprite = in_full_r && sprite_free;
    in_ready    = !in_full_r || load_sprite;
    load_in     = in_valid && in_ready;

    in_full_nxt   = load_in || (in_full_r && !load_sprite);
    out_valid_nxt = load_vert || (out_valid_r && !out_ready);
    state_nxt     = state_r;
    corner_nxt    = corner_r;
    priority if (load_sprite) begin
      state_nxt  = S_EMIT;
      corner_nxt = CORNER_FIRST;
    end else if (load_vert && last) begin
      state_nxt  = S_EMPTY;
    end else if (load_vert) begin
      corner_nxt = corner_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_EMPTY;
      corner_r    <= CORNER_FIRST;
      in_full_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      corner_r    <= corner_nxt;
      in_full_r   <= in_full_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign cmd = '{load_in: load_in, load_sprite: load_sprite,
                 load_vert: load_vert, corner: corner_r};

  `ASSERT_NXT(a_hold_in, load_in, in_full_r)
  `ASSERT_NXT(a_quad_done, load_vert && last && !load_sprite, state_r == S_EMPTY)
  `ASSERT_NXT(a_stall_corner, (state_r == S_EMIT) && out_valid_r && !out_ready,
              $stable(corner_r))

endmodule

`default_nettype wire

### rtl/sqve_dp.sv
`default_nettype none

module sqve_dp #(
  parameter int SLOT_COUNT = 8
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire sqve_pkg::sqve_cmd_t cmd,
  input  wire sqve_pkg::sqve_in_t  in_data,
  output sqve_pkg::sqve_out_t      out_data
);
  import sqve_pkg::*;

  localparam int CNT_W = $clog2(SLOT_COUNT + 1);
  localparam int IDX_W = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

  typedef struct packed {
    logic [31:0]      pos_x;
    logic [31:0]      pos_y;
    logic [31:0]      half_x;
    logic [31:0]      half_y;
    logic [31:0]      u_left;
    logic [31:0]      u_right;
    logic [31:0]      v_top;
    logic [31:0]      v_bottom;
    logic [31:0]      colour;
    logic [31:0]      rotation;
    logic [3:0]       slot;
    logic             overflow;
  } sqve_sprite_t;

  sqve_in_t     in_r;
  sqve_sprite_t sprite_r, sprite_nxt;
  sqve_out_t    out_r, out_nxt;
  logic [31:0]  slot_ids_r [SLOT_COUNT];
  logic [CNT_W-1:0] slots_used_r, slots_used_nxt;
  logic [CNT_W-1:0] used_eff, hit_slot, new_slot, slot_val;
  logic [31:0]  slot_wide;
  logic         found, full, do_append;

  always_comb begin
    used_eff = in_r.batch_start ? '0 : slots_used_r;
    found    = 1'b0;
    hit_slot = '0;
    for (int i = 0; i < SLOT_COUNT; i++) begin
      if (!found && (CNT_W'(i) < used_eff) && (slot_ids_r[i] == in_r.texture_id)) begin
        found    = 1'b1;
        hit_slot = CNT_W'(i + 1);
      end
    end
    full      = used_eff == CNT_W'(SLOT_COUNT);
    new_slot  = used_eff + CNT_W'(1);
    do_append = !found && !full;
    slot_val  = found ? hit_slot : (do_append ? new_slot : '0);
    slot_wide = 32'(slot_val);

    slots_used_nxt = slots_used_r;
    if (cmd.load_sprite) begin
      slots_used_nxt = do_append ? new_slot : used_eff;
    end

    sprite_nxt.pos_x    = in_r.pos_x;
    sprite_nxt.pos_y    = in_r.pos_y;
    sprite_nxt.half_x   = {in_r.size_x[31], in_r.size_x[31:1]};
    sprite_nxt.half_y   = {in_r.size_y[31], in_r.size_y[31:1]};
    sprite_nxt.u_left   = in_r.uv_left;
    sprite_nxt.u_right  = in_r.uv_left + in_r.uv_width;
    sprite_nxt.v_top    = in_r.uv_top;
    sprite_nxt.v_bottom = in_r.uv_top + in_r.uv_height;
    sprite_nxt.colour   = {chan8(in_r.color_rgba[63:48]), chan8(in_r.color_rgba[47:32]),
                           chan8(in_r.color_rgba[31:16]), chan8(in_r.color_rgba[15:0])};
    sprite_nxt.rotation = in_r.rotation;
    sprite_nxt.slot     = slot_wide[3:0];
    sprite_nxt.overflow = !found && full;
  end

  always_comb begin
    out_nxt.vert_pos_x    = sprite_r.pos_x;
    out_nxt.vert_pos_y    = sprite_r.pos_y;
    out_nxt.offset_x      = cmd.corner[1] ? sprite_r.half_x : 32'd0 - sprite_r.half_x;
    out_nxt.offset_y      = (cmd.corner == CORNER_FIRST || cmd.corner == CORNER_LAST) ?
                            sprite_r.half_y : 32'd0 - sprite_r.half_y;
    out_nxt.tex_u         = cmd.corner[1] ? sprite_r.u_right : sprite_r.u_left;
    out_nxt.tex_v         = (cmd.corner == CORNER_FIRST || cmd.corner == CORNER_LAST) ?
                            sprite_r.v_top : sprite_r.v_bottom;
    out_nxt.packed_color  = sprite_r.colour;
    out_nxt.vert_rotation = sprite_r.rotation;
    out_nxt.tex_slot      = sprite_r.slot;
    out_nxt.slot_overflow = sprite_r.overflow;
    out_nxt.corner        = cmd.corner;
    out_nxt.last_corner   = cmd.corner == CORNER_LAST;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slots_used_r <= '0;
    end else begin
      slots_used_r <= slots_used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      in_r <= in_data;
    end
    if (cmd.load_sprite) begin
      sprite_r <= sprite_nxt;
    end
    if (cmd.load_sprite && do_append) begin
      slot_ids_r[used_eff[IDX_W-1:0]] <= in_r.texture_id;
    end
    if (cmd.load_vert) begin
      out_r <= out_nxt;
    end
  end

  assign out_data = out_r;

endmodule

`default_nettype wire
